[sv/fibp_pkg.sv]
// fibp_pkg: shared types, register codes, reset values and the sine table
// entry function for the footprint-in-box path check.
// No dependencies; used by every module of the block.
package fibp_pkg;

  localparam int SINE_TABLE_ENTRIES = 256;
  localparam int MARGIN_MM          = 100;

  localparam int POS_W   = 20;              // pose and slot coordinates
  localparam int CMP_W   = 22;              // world coordinates and bounds
  localparam int LOC_W   = 17;              // vehicle-frame corner offsets
  localparam int TRIG_W  = 16;              // signed q1.15 sine and cosine
  localparam int MAG_W   = 15;              // table entry magnitude
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam logic [63:0] Q30_HALF_PI  = 64'd1686629713;
  localparam logic [63:0] Q15_MAX      = 64'd32767;

  // register index codes (byte address bits 4..2)
  localparam logic [2:0] REG_REAR_OVERHANG  = 3'd0;
  localparam logic [2:0] REG_WHEELBASE      = 3'd1;
  localparam logic [2:0] REG_FRONT_OVERHANG = 3'd2;
  localparam logic [2:0] REG_VEHICLE_WIDTH  = 3'd3;
  localparam logic [2:0] REG_BOX_LO_X       = 3'd4;
  localparam logic [2:0] REG_BOX_HI_X       = 3'd5;
  localparam logic [2:0] REG_BOX_LO_Y       = 3'd6;
  localparam logic [2:0] REG_BOX_HI_Y       = 3'd7;

  localparam logic [12:0] REAR_OVERHANG_RESET  = 13'd900;
  localparam logic [13:0] WHEELBASE_RESET      = 14'd2700;
  localparam logic [12:0] FRONT_OVERHANG_RESET = 13'd900;
  localparam logic [12:0] VEHICLE_WIDTH_RESET  = 13'd1800;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [15:0]             heading;
    logic                    end_of_path;
  } pose_t;

  typedef struct packed {
    logic pose_outside;
    logic path_clear;
    logic path_done;
  } verdict_t;

  typedef struct packed {
    logic [12:0]             rear_overhang_mm;
    logic [13:0]             wheelbase_mm;
    logic [12:0]             front_overhang_mm;
    logic [12:0]             vehicle_width_mm;
    logic signed [POS_W-1:0] box_lo_x;
    logic signed [POS_W-1:0] box_hi_x;
    logic signed [POS_W-1:0] box_lo_y;
    logic signed [POS_W-1:0] box_hi_y;
  } cfg_t;

  // q1.15 sine of a q30 angle in [0, pi/2], eight-term taylor series,
  // evaluated at elaboration only
  function automatic logic [MAG_W-1:0] sine_q15(input logic [63:0] x);
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    term = x;
    sum  = signed'(x);
    term = (term * x) >> 30;  term = (term * x) >> 30;  term = term / 64'd6;
    sum  = sum - signed'(term);
    term = (term * x) >> 30;  term = (term * x) >> 30;  term = term / 64'd20;
    sum  = sum + signed'(term);
    term = (term * x) >> 30;  term = (term * x) >> 30;  term = term / 64'd42;
    sum  = sum - signed'(term);
    term = (term * x) >> 30;  term = (term * x) >> 30;  term = term / 64'd72;
    sum  = sum + signed'(term);
    term = (term * x) >> 30;  term = (term * x) >> 30;  term = term / 64'd110;
    sum  = sum - signed'(term);
    term = (term * x) >> 30;  term = (term * x) >> 30;  term = term / 64'd156;
    sum  = sum + signed'(term);
    term = (term * x) >> 30;  term = (term * x) >> 30;  term = term / 64'd210;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    r = (unsigned'(sum) * Q15_MAX + (64'd1 << 29)) >> 30;
    if (r > Q15_MAX) begin
      r = Q15_MAX;
    end
    return r[MAG_W-1:0];
  endfunction

endpackage

[sv/fibp_sine.sv]
// fibp_sine: q1.15 sine of a 16-bit binary angle from a quarter-wave table.
// Table is built at elaboration with fibp_pkg::sine_q15; depends on fibp_pkg.
module fibp_sine #(
  parameter int SINE_TABLE_ENTRIES = fibp_pkg::SINE_TABLE_ENTRIES
) (
  input  logic [15:0]                         angle,
  output logic signed [fibp_pkg::TRIG_W-1:0]  sine
);

  localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int PW = 14 + IW;

  logic [fibp_pkg::MAG_W-1:0] tab [0:SINE_TABLE_ENTRIES];

  for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_tab
    localparam logic [63:0] X = fibp_pkg::Q30_HALF_PI * 64'(k) / 64'(SINE_TABLE_ENTRIES);
    assign tab[k] = fibp_pkg::sine_q15(X);
  end

  logic [PW-1:0]                   prod;
  logic [IW-1:0]                   idx;
  logic [IW-1:0]                   sel;
  logic signed [fibp_pkg::TRIG_W-1:0] mag;

  // index = angle within quadrant scaled to table entries, truncated
  assign prod = PW'(angle[13:0]) * PW'(SINE_TABLE_ENTRIES);
  assign idx  = prod[PW-1:14];
  // odd quadrants run the table backwards
  assign sel  = angle[14] ? (IW'(SINE_TABLE_ENTRIES) - idx) : idx;
  assign mag  = $signed({1'b0, tab[sel]});
  assign sine = angle[15] ? -mag : mag;

endmodule

[sv/fibp_corner_check.sv]
// fibp_corner_check: rotates and translates the four footprint corners and
// tests them against the slot box plus margin. Depends on fibp_pkg.
module fibp_corner_check #(
  parameter int MARGIN_MM = fibp_pkg::MARGIN_MM
) (
  input  fibp_pkg::cfg_t                        geom,
  input  logic signed [fibp_pkg::POS_W-1:0]     pos_x,
  input  logic signed [fibp_pkg::POS_W-1:0]     pos_y,
  input  logic signed [fibp_pkg::TRIG_W-1:0]    sine,
  input  logic signed [fibp_pkg::TRIG_W-1:0]    cosine,
  output logic                                  outside
);

  localparam int LW = fibp_pkg::LOC_W;
  localparam int PW = fibp_pkg::LOC_W + fibp_pkg::TRIG_W;
  localparam int FW = PW - 15;
  localparam int CW = fibp_pkg::CMP_W;
  localparam logic signed [CW-1:0] MARGIN = CW'(MARGIN_MM);

  logic signed [LW-1:0] rear, front, hw, nhw;
  logic signed [LW-1:0] lx [4];
  logic signed [LW-1:0] ly [4];
  logic signed [PW-1:0] p_xc [4];
  logic signed [PW-1:0] p_ys [4];
  logic signed [PW-1:0] p_xs [4];
  logic signed [PW-1:0] p_yc [4];
  logic signed [FW-1:0] f_xc [4];
  logic signed [FW-1:0] f_ys [4];
  logic signed [FW-1:0] f_xs [4];
  logic signed [FW-1:0] f_yc [4];
  logic signed [CW-1:0] wx [4];
  logic signed [CW-1:0] wy [4];
  logic [3:0]           hit;
  logic signed [CW-1:0] min_x, max_x, min_y, max_y;

  assign rear  = -$signed({4'b0000, geom.rear_overhang_mm});
  assign front = $signed(LW'(geom.wheelbase_mm) + LW'(geom.front_overhang_mm));
  assign hw    = $signed({5'b00000, geom.vehicle_width_mm[12:1]});
  assign nhw   = -hw;

  assign lx[0] = rear;   assign ly[0] = hw;
  assign lx[1] = front;  assign ly[1] = hw;
  assign lx[2] = front;  assign ly[2] = nhw;
  assign lx[3] = rear;   assign ly[3] = nhw;

  assign min_x = CW'(geom.box_lo_x) - MARGIN;
  assign max_x = CW'(geom.box_hi_x) + MARGIN;
  assign min_y = CW'(geom.box_lo_y) - MARGIN;
  assign max_y = CW'(geom.box_hi_y) + MARGIN;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      p_xc[k] = lx[k] * cosine;
      p_ys[k] = ly[k] * sine;
      p_xs[k] = lx[k] * sine;
      p_yc[k] = ly[k] * cosine;
      // dropping the low 15 bits floors toward minus infinity
      f_xc[k] = p_xc[k][PW-1:15];
      f_ys[k] = p_ys[k][PW-1:15];
      f_xs[k] = p_xs[k][PW-1:15];
      f_yc[k] = p_yc[k][PW-1:15];
      wx[k]   = CW'(pos_x) + CW'(f_xc[k]) - CW'(f_ys[k]);
      wy[k]   = CW'(pos_y) + CW'(f_xs[k]) + CW'(f_yc[k]);
      hit[k]  = (wx[k] < min_x) || (wx[k] > max_x) || (wy[k] < min_y) || (wy[k] > max_y);
    end
  end

  assign outside = |hit;

endmodule

[sv/footprint_in_box_path_check_unit.sv]
// footprint_in_box_path_check_unit: top level with config registers, the
// two-register pose pipeline and the sticky path verdict.
// Depends on fibp_pkg, fibp_sine and fibp_corner_check.
//
// Usage: path poses enter on the pose channel (pose_valid, pose_stall, pose)
// one per request, and each produces exactly one verdict on the verdict
// channel (verdict_valid, verdict_stall, verdict) in the same order.
// A pose is captured into an input register; table lookup, the corner
// multiplies, sums and box compares run combinationally from that register
// into the verdict register. Throughput is one pose per cycle while the
// receiver does not stall.
// path_clear ANDs !pose_outside over the path so far; after a pose with
// end_of_path set the running flag starts clear again. path_done echoes
// end_of_path, so path_clear on that verdict is the path's final result.
// When the receiver stalls, the verdict holds and the input register keeps
// taking one more pose; after that pose_stall rises until the verdict goes.
// Reset empties both registers, sets the running flag clear and loads the
// geometry defaults with a zero slot box. Registers sit on an APB port at
// byte address 4*index; write only while the block is idle (not enforced).
module footprint_in_box_path_check_unit #(
  parameter int SINE_TABLE_ENTRIES = fibp_pkg::SINE_TABLE_ENTRIES,
  parameter int MARGIN_MM          = fibp_pkg::MARGIN_MM
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fibp_pkg::ADDR_W-1:0]   paddr,
  input  logic [fibp_pkg::DATA_W-1:0]   pwdata,
  output logic [fibp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          pose_valid,
  output logic                          pose_stall,
  input  fibp_pkg::pose_t               pose,
  output logic                          verdict_valid,
  input  logic                          verdict_stall,
  output fibp_pkg::verdict_t            verdict
);

  fibp_pkg::cfg_t     cfg;
  fibp_pkg::pose_t    s1_pose;
  logic               s1_valid;
  logic               clear_so_far;
  logic               advance;
  logic               take;
  logic               cfg_write;
  logic [2:0]         reg_index;
  logic [15:0]        cos_angle;
  logic signed [fibp_pkg::TRIG_W-1:0] sine, cosine;
  logic               outside;
  logic               clear_now;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rear_overhang_mm  <= fibp_pkg::REAR_OVERHANG_RESET;
      cfg.wheelbase_mm      <= fibp_pkg::WHEELBASE_RESET;
      cfg.front_overhang_mm <= fibp_pkg::FRONT_OVERHANG_RESET;
      cfg.vehicle_width_mm  <= fibp_pkg::VEHICLE_WIDTH_RESET;
      cfg.box_lo_x          <= '0;
      cfg.box_hi_x          <= '0;
      cfg.box_lo_y          <= '0;
      cfg.box_hi_y          <= '0;
    end else if (cfg_write) begin
      unique case (reg_index)
        fibp_pkg::REG_REAR_OVERHANG:  cfg.rear_overhang_mm  <= pwdata[12:0];
        fibp_pkg::REG_WHEELBASE:      cfg.wheelbase_mm      <= pwdata[13:0];
        fibp_pkg::REG_FRONT_OVERHANG: cfg.front_overhang_mm <= pwdata[12:0];
        fibp_pkg::REG_VEHICLE_WIDTH:  cfg.vehicle_width_mm  <= pwdata[12:0];
        fibp_pkg::REG_BOX_LO_X:       cfg.box_lo_x          <= $signed(pwdata[19:0]);
        fibp_pkg::REG_BOX_HI_X:       cfg.box_hi_x          <= $signed(pwdata[19:0]);
        fibp_pkg::REG_BOX_LO_Y:       cfg.box_lo_y          <= $signed(pwdata[19:0]);
        fibp_pkg::REG_BOX_HI_Y:       cfg.box_hi_y          <= $signed(pwdata[19:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      fibp_pkg::REG_REAR_OVERHANG:  prdata = 32'(cfg.rear_overhang_mm);
      fibp_pkg::REG_WHEELBASE:      prdata = 32'(cfg.wheelbase_mm);
      fibp_pkg::REG_FRONT_OVERHANG: prdata = 32'(cfg.front_overhang_mm);
      fibp_pkg::REG_VEHICLE_WIDTH:  prdata = 32'(cfg.vehicle_width_mm);
      fibp_pkg::REG_BOX_LO_X:       prdata = 32'(unsigned'(cfg.box_lo_x));
      fibp_pkg::REG_BOX_HI_X:       prdata = 32'(unsigned'(cfg.box_hi_x));
      fibp_pkg::REG_BOX_LO_Y:       prdata = 32'(unsigned'(cfg.box_lo_y));
      fibp_pkg::REG_BOX_HI_Y:       prdata = 32'(unsigned'(cfg.box_hi_y));
      default:                      prdata = '0;
    endcase
  end

  // the verdict register frees up when empty or when its request is taken
  assign advance    = !verdict_valid || !verdict_stall;
  assign pose_stall = s1_valid && !advance;
  assign take       = pose_valid && !pose_stall;

  assign cos_angle = s1_pose.heading + fibp_pkg::QUARTER_TURN;

  fibp_sine #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_sine (
    .angle (s1_pose.heading),
    .sine  (sine)
  );

  fibp_sine #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_cosine (
    .angle (cos_angle),
    .sine  (cosine)
  );

  fibp_corner_check #(
    .MARGIN_MM(MARGIN_MM)
  ) u_check (
    .geom    (cfg),
    .pos_x   (s1_pose.pos_x),
    .pos_y   (s1_pose.pos_y),
    .sine    (sine),
    .cosine  (cosine),
    .outside (outside)
  );

  assign clear_now = clear_so_far && !outside;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      verdict_valid <= 1'b0;
      clear_so_far  <= 1'b1;
    end else begin
      if (advance) begin
        verdict_valid <= s1_valid;
        if (s1_valid) begin
          clear_so_far <= s1_pose.end_of_path ? 1'b1 : clear_now;
        end
      end
      if (take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pose <= pose;
    end
    if (advance && s1_valid) begin
      verdict.pose_outside <= outside;
      verdict.path_clear   <= clear_now;
      verdict.path_done    <= s1_pose.end_of_path;
    end
  end

endmodule
